[rtl/cqs_pkg.sv]
// Package of types, constants and helper functions for the calendar queue scheduler.
package cqs_pkg;

    localparam int NUM_BUCKETS  = 4096;
    localparam int PACKET_SLOTS = 1024;

    localparam int HANDLE_W = 10;
    localparam int TIME_W   = 64;
    localparam int GRAN_W   = 32;
    localparam int HOR_W    = 48;
    localparam int CAP_W    = 11;
    localparam int CFG_AW   = 2;
    localparam int BKT_AW   = $clog2(NUM_BUCKETS);
    localparam int SLOT_AW  = $clog2(PACKET_SLOTS);
    localparam int CNT_W    = $clog2(PACKET_SLOTS + 1);
    localparam int STEP_W   = $clog2(NUM_BUCKETS + 1);
    localparam int DIV_CW   = $clog2(TIME_W);

    localparam logic [GRAN_W-1:0] RESET_GRAN    = GRAN_W'(10000);
    localparam logic [HOR_W-1:0]  RESET_HORIZON = HOR_W'(64'd20000000000);
    localparam logic [CAP_W-1:0]  RESET_LIMIT   = CAP_W'(1024);
    localparam logic [TIME_W-1:0] TIME_MAX      = {TIME_W{1'b1}};

    localparam logic [CFG_AW-1:0] CFG_GRAN    = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_HORIZON = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_LIMIT   = 2'd2;

    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    typedef struct packed {
        logic                req_type;
        logic [HANDLE_W-1:0] packet_handle;
        logic [TIME_W-1:0]   send_time;
        logic [TIME_W-1:0]   current_time;
    } t_in;

    typedef struct packed {
        logic                dropped;
        logic                out_valid;
        logic [HANDLE_W-1:0] out_handle;
        logic                queue_empty;
    } t_out;

    typedef struct packed {
        logic [GRAN_W-1:0] gran;
        logic [HOR_W-1:0]  horizon;
        logic [CAP_W-1:0]  limit;
    } t_cfg;

    typedef struct packed {
        logic [CNT_W-1:0]    len;
        logic [HANDLE_W-1:0] tail;
        logic [HANDLE_W-1:0] head;
    } t_bkt;

    typedef struct packed {
        logic valid;
        t_in  item;
    } t_fq;

    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] dividend;
        logic [GRAN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [TIME_W-1:0] quotient;
    } t_div_rsp;

    typedef struct packed {
        logic             clearing;
        logic [CNT_W-1:0] held;
    } t_bk_stat;

    typedef enum logic [3:0] {
        BK_CLEAR, BK_IDLE, BK_EQ_DIV, BK_EQ_RD, BK_EQ_UPD, BK_EQ_LNK,
        BK_DQ_DIV1, BK_DQ_DIV2, BK_DQ_RD, BK_DQ_CHK, BK_DQ_SAT, BK_DQ_POP
    } t_bk_state;

    function automatic logic [SLOT_AW-1:0] link_slot(input logic [HANDLE_W-1:0] h);
        return SLOT_AW'(h % PACKET_SLOTS);
    endfunction

    function automatic logic [BKT_AW-1:0] bucket_idx(input logic [TIME_W-1:0] q);
        return BKT_AW'(q % NUM_BUCKETS);
    endfunction

endpackage

[rtl/calendar_queue_scheduler_core.sv]
// Top level of the calendar queue scheduler: configuration registers, front end and back end.
//
// A request word is accepted on a rising edge with i_start high and o_busy low.
// Enqueue words clamp the send time to the window and append the handle to the
// bucket FIFO; dequeue words scan forward from the window start and pop at most one packet.
// Every word gives exactly one result word on o_result, marked by o_done for one
// cycle; the receiver cannot hold results off, and results keep request order.
// A two-entry queue sits between front and back, so two words may wait while
// the back end works. An enqueue maps its time to a bucket with the 64-step
// bit-serial divider. A dequeue runs two divisions, then scans one bucket at a
// time past empty ones, up to the bucket count, and runs one more division if
// the window start saturates. A dropped enqueue or a dequeue on an empty store
// runs no division.
// Configuration words are taken on i_cfg_valid with o_cfg_ready always high,
// and must be written only while the block is idle.
// After reset the bucket store is cleared one bucket per cycle across all 4096
// buckets; o_busy is high while the clearing runs.
module calendar_queue_scheduler_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  cqs_pkg::t_in                i_item,
    output logic                        o_done,
    output cqs_pkg::t_out               o_result,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [cqs_pkg::CFG_AW-1:0]  i_cfg_index,
    input  logic [cqs_pkg::HOR_W-1:0]   i_cfg_data
);
    cqs_pkg::t_cfg     r_cfg;
    cqs_pkg::t_fq      w_head;
    cqs_pkg::t_bk_stat w_stat;
    logic              w_full, w_pop, w_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gran    <= cqs_pkg::RESET_GRAN;
            r_cfg.horizon <= cqs_pkg::RESET_HORIZON;
            r_cfg.limit   <= cqs_pkg::RESET_LIMIT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                cqs_pkg::CFG_GRAN:    r_cfg.gran    <= i_cfg_data[cqs_pkg::GRAN_W-1:0];
                cqs_pkg::CFG_HORIZON: r_cfg.horizon <= i_cfg_data;
                cqs_pkg::CFG_LIMIT:   r_cfg.limit   <= i_cfg_data[cqs_pkg::CAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_busy      = w_full | w_stat.clearing;
    assign w_push      = i_start & ~o_busy;

    cqs_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_item(i_item),
        .i_pop(w_pop), .o_head(w_head), .o_full(w_full)
    );

    cqs_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg), .i_head(w_head),
        .o_pop(w_pop), .o_done(o_done), .o_result(o_result), .o_stat(w_stat)
    );

    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_result.dropped && o_result.out_valid))
        else $error("result both dropped and valid");

    a_handle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.out_valid) |-> (o_result.out_handle == '0))
        else $error("handle not zero without a packet");

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(w_stat.held) <= 32'(cqs_pkg::PACKET_SLOTS))
        else $error("held count above store size");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.queue_empty == (w_stat.held == '0)))
        else $error("empty flag disagrees with held count");
endmodule

[rtl/cqs_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
module cqs_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/cqs_div.sv]
// Radix-2 restoring divider that divides a time word by the bucket granularity.
module cqs_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cqs_pkg::t_div_req  i_req,
    output cqs_pkg::t_div_rsp  o_rsp
);
    logic                             r_busy, n_busy;
    logic                             r_done, n_done;
    logic [cqs_pkg::DIV_CW-1:0]       r_cnt, n_cnt;
    logic [cqs_pkg::GRAN_W-1:0]       r_rem, n_rem;
    logic [cqs_pkg::TIME_W-1:0]       r_quo, n_quo;
    logic [cqs_pkg::GRAN_W-1:0]       r_den, n_den;
    logic [cqs_pkg::GRAN_W:0]         w_sh;
    logic                             w_ge;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        w_sh   = {r_rem, r_quo[cqs_pkg::TIME_W-1]};
        w_ge   = w_sh >= {1'b0, r_den};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_den  = i_req.divisor;
        end else if (r_busy) begin
            n_rem = w_ge ? cqs_pkg::GRAN_W'(w_sh - {1'b0, r_den})
                         : cqs_pkg::GRAN_W'(w_sh);
            n_quo = {r_quo[cqs_pkg::TIME_W-2:0], w_ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == cqs_pkg::DIV_CW'(cqs_pkg::TIME_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule

[rtl/cqs_front.sv]
// Front end that accepts request words into a two-entry queue for the back end.
module cqs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cqs_pkg::t_in  i_item,
    input  logic          i_pop,
    output cqs_pkg::t_fq  o_head,
    output logic          o_full
);
    cqs_pkg::t_in r_q [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt, n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
        end
        if (i_push) begin
            r_q[r_wp] <= i_item;
        end
    end

    assign o_head.valid = r_cnt != 2'd0;
    assign o_head.item  = r_q[r_rp];
    assign o_full       = r_cnt == 2'd2;
endmodule

[rtl/cqs_back.sv]
// Back end that clears the bucket store, enqueues packets and scans buckets on dequeue.
module cqs_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cqs_pkg::t_cfg     i_cfg,
    input  cqs_pkg::t_fq      i_head,
    output logic              o_pop,
    output logic              o_done,
    output cqs_pkg::t_out     o_result,
    output cqs_pkg::t_bk_stat o_stat
);
    cqs_pkg::t_bk_state r_state, n_state;
    logic [cqs_pkg::TIME_W-1:0]   r_ws, n_ws, r_we, n_we;
    logic [cqs_pkg::CNT_W-1:0]    r_held, n_held;
    cqs_pkg::t_in                 r_item, n_item;
    logic [cqs_pkg::BKT_AW-1:0]   r_b, n_b;
    logic [cqs_pkg::TIME_W-1:0]   r_qws, n_qws, r_qnow, n_qnow;
    logic [cqs_pkg::STEP_W-1:0]   r_steps, n_steps;
    logic                         r_last, n_last;
    logic [cqs_pkg::HANDLE_W-1:0] r_tail, n_tail;
    logic                         r_done, n_done;
    cqs_pkg::t_out                r_res, n_res;

    cqs_pkg::t_div_req            w_dreq;
    cqs_pkg::t_div_rsp            w_drsp;
    logic                         w_bwe, w_lwe;
    logic [cqs_pkg::BKT_AW-1:0]   w_bwaddr;
    cqs_pkg::t_bkt                w_bwdata, w_brdata;
    logic [cqs_pkg::SLOT_AW-1:0]  w_lwaddr;
    logic [cqs_pkg::HANDLE_W-1:0] w_lwdata, w_lrdata;
    logic [cqs_pkg::GRAN_W-1:0]   w_g;
    logic [31:0]                  w_lim;
    logic [cqs_pkg::TIME_W-1:0]   w_t1, w_t2;
    logic [cqs_pkg::TIME_W:0]     w_sum;

    cqs_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));

    cqs_ram #(.W($bits(cqs_pkg::t_bkt)), .D(cqs_pkg::NUM_BUCKETS)) u_bkt_ram (
        .i_clk(i_clk), .i_we(w_bwe), .i_waddr(w_bwaddr), .i_wdata(w_bwdata),
        .i_raddr(r_b), .o_rdata(w_brdata)
    );

    cqs_ram #(.W(cqs_pkg::HANDLE_W), .D(cqs_pkg::PACKET_SLOTS)) u_link_ram (
        .i_clk(i_clk), .i_we(w_lwe), .i_waddr(w_lwaddr), .i_wdata(w_lwdata),
        .i_raddr(cqs_pkg::link_slot(w_brdata.head)), .o_rdata(w_lrdata)
    );

    always_comb begin
        n_state  = r_state;
        n_ws     = r_ws;
        n_we     = r_we;
        n_held   = r_held;
        n_item   = r_item;
        n_b      = r_b;
        n_qws    = r_qws;
        n_qnow   = r_qnow;
        n_steps  = r_steps;
        n_last   = r_last;
        n_tail   = r_tail;
        n_done   = 1'b0;
        n_res    = r_res;
        o_pop    = 1'b0;
        w_dreq   = '0;
        w_bwe    = 1'b0;
        w_bwaddr = r_b;
        w_bwdata = w_brdata;
        w_lwe    = 1'b0;
        w_lwaddr = cqs_pkg::link_slot(r_item.packet_handle);
        w_lwdata = '0;
        w_g      = (i_cfg.gran == '0) ? cqs_pkg::GRAN_W'(1) : i_cfg.gran;
        w_lim    = (32'(i_cfg.limit) > 32'(cqs_pkg::PACKET_SLOTS))
                 ? 32'(cqs_pkg::PACKET_SLOTS) : 32'(i_cfg.limit);
        w_t1     = (i_head.item.send_time < r_ws) ? r_ws : i_head.item.send_time;
        w_t2     = (w_t1 > r_we) ? r_we : w_t1;
        w_sum    = {1'b0, i_head.item.current_time} + (cqs_pkg::TIME_W + 1)'(i_cfg.horizon);
        w_dreq.divisor = w_g;

        case (r_state)
            cqs_pkg::BK_CLEAR: begin
                w_bwe    = 1'b1;
                w_bwdata = '0;
                n_b      = r_b + 1'b1;
                if (r_b == cqs_pkg::BKT_AW'(cqs_pkg::NUM_BUCKETS - 1)) begin
                    n_state = cqs_pkg::BK_IDLE;
                end
            end
            cqs_pkg::BK_IDLE: begin
                if (i_head.valid) begin
                    o_pop  = 1'b1;
                    n_item = i_head.item;
                    n_res  = '0;
                    if (i_head.item.req_type == cqs_pkg::REQ_ENQ) begin
                        if (32'(r_held) >= w_lim) begin
                            n_done            = 1'b1;
                            n_res.dropped     = 1'b1;
                            n_res.queue_empty = r_held == '0;
                        end else begin
                            w_dreq.start    = 1'b1;
                            w_dreq.dividend = w_t2;
                            n_state         = cqs_pkg::BK_EQ_DIV;
                        end
                    end else if (r_held == '0) begin
                        n_ws              = i_head.item.current_time;
                        n_we              = w_sum[cqs_pkg::TIME_W] ? cqs_pkg::TIME_MAX
                                          : w_sum[cqs_pkg::TIME_W-1:0];
                        n_done            = 1'b1;
                        n_res.queue_empty = 1'b1;
                    end else begin
                        w_dreq.start    = 1'b1;
                        w_dreq.dividend = r_ws;
                        n_state         = cqs_pkg::BK_DQ_DIV1;
                    end
                end
            end
            cqs_pkg::BK_EQ_DIV: begin
                if (w_drsp.done) begin
                    n_b     = cqs_pkg::bucket_idx(w_drsp.quotient);
                    n_state = cqs_pkg::BK_EQ_RD;
                end
            end
            cqs_pkg::BK_EQ_RD: begin
                n_state = cqs_pkg::BK_EQ_UPD;
            end
            cqs_pkg::BK_EQ_UPD: begin
                w_lwe         = 1'b1;
                w_bwe         = 1'b1;
                w_bwdata.len  = w_brdata.len + 1'b1;
                w_bwdata.tail = r_item.packet_handle;
                if (w_brdata.len == '0) begin
                    w_bwdata.head = r_item.packet_handle;
                end
                n_tail = w_brdata.tail;
                n_held = r_held + 1'b1;
                if (w_brdata.len == '0) begin
                    n_done  = 1'b1;
                    n_state = cqs_pkg::BK_IDLE;
                end else begin
                    n_state = cqs_pkg::BK_EQ_LNK;
                end
            end
            cqs_pkg::BK_EQ_LNK: begin
                w_lwe    = 1'b1;
                w_lwaddr = cqs_pkg::link_slot(r_tail);
                w_lwdata = r_item.packet_handle;
                n_done   = 1'b1;
                n_state  = cqs_pkg::BK_IDLE;
            end
            cqs_pkg::BK_DQ_DIV1: begin
                if (w_drsp.done) begin
                    n_qws           = w_drsp.quotient;
                    w_dreq.start    = 1'b1;
                    w_dreq.dividend = r_item.current_time;
                    n_state         = cqs_pkg::BK_DQ_DIV2;
                end
            end
            cqs_pkg::BK_DQ_DIV2: begin
                if (w_drsp.done) begin
                    n_qnow  = w_drsp.quotient;
                    n_b     = cqs_pkg::bucket_idx(r_qws);
                    n_steps = '0;
                    n_last  = 1'b0;
                    n_state = cqs_pkg::BK_DQ_RD;
                end
            end
            cqs_pkg::BK_DQ_RD: begin
                n_state = cqs_pkg::BK_DQ_CHK;
            end
            cqs_pkg::BK_DQ_CHK: begin
                if (w_brdata.len != '0) begin
                    n_state = cqs_pkg::BK_DQ_POP;
                end else if (r_last || r_qws >= r_qnow
                             || r_steps == cqs_pkg::STEP_W'(cqs_pkg::NUM_BUCKETS)) begin
                    n_done            = 1'b1;
                    n_res.queue_empty = r_held == '0;
                    n_state           = cqs_pkg::BK_IDLE;
                end else if (r_ws > cqs_pkg::TIME_MAX - cqs_pkg::TIME_W'(w_g)) begin
                    n_ws            = cqs_pkg::TIME_MAX;
                    w_dreq.start    = 1'b1;
                    w_dreq.dividend = cqs_pkg::TIME_MAX;
                    n_state         = cqs_pkg::BK_DQ_SAT;
                end else begin
                    n_ws    = r_ws + cqs_pkg::TIME_W'(w_g);
                    n_qws   = r_qws + 1'b1;
                    n_b     = cqs_pkg::bucket_idx(r_qws + 1'b1);
                    n_steps = r_steps + 1'b1;
                    n_state = cqs_pkg::BK_DQ_RD;
                end
            end
            cqs_pkg::BK_DQ_SAT: begin
                if (w_drsp.done) begin
                    n_b     = cqs_pkg::bucket_idx(w_drsp.quotient);
                    n_last  = 1'b1;
                    n_state = cqs_pkg::BK_DQ_RD;
                end
            end
            cqs_pkg::BK_DQ_POP: begin
                w_bwe             = 1'b1;
                w_bwdata.len      = w_brdata.len - 1'b1;
                w_bwdata.head     = w_lrdata;
                n_held            = r_held - 1'b1;
                n_done            = 1'b1;
                n_res.out_valid   = 1'b1;
                n_res.out_handle  = w_brdata.head;
                n_res.queue_empty = n_held == '0;
                n_state           = cqs_pkg::BK_IDLE;
            end
            default: begin
                n_state = cqs_pkg::BK_IDLE;
            end
        endcase

        if (r_state == cqs_pkg::BK_EQ_UPD || r_state == cqs_pkg::BK_EQ_LNK) begin
            n_res.queue_empty = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cqs_pkg::BK_CLEAR;
            r_ws    <= '0;
            r_we    <= cqs_pkg::TIME_W'(cqs_pkg::RESET_HORIZON);
            r_held  <= '0;
            r_b     <= '0;
            r_done  <= 1'b0;
            r_res   <= '0;
        end else begin
            r_state <= n_state;
            r_ws    <= n_ws;
            r_we    <= n_we;
            r_held  <= n_held;
            r_b     <= n_b;
            r_done  <= n_done;
            r_res   <= n_res;
        end
        r_item  <= n_item;
        r_qws   <= n_qws;
        r_qnow  <= n_qnow;
        r_steps <= n_steps;
        r_last  <= n_last;
        r_tail  <= n_tail;
    end

    assign o_done         = r_done;
    assign o_result       = r_res;
    assign o_stat.clearing = r_state == cqs_pkg::BK_CLEAR;
    assign o_stat.held     = r_held;
endmodule
